// File: design/lattice_site_index_generator_assert.svh
// Assertion macros for the lattice site index generator RTL.
// Included by the top module, which checks its own pipeline and register behavior.
`ifndef LATTICE_SITE_INDEX_GENERATOR_ASSERT_SVH
`define LATTICE_SITE_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define LSIG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define LSIG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles under an active-low reset.
`define LSIG_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: design/lsig_pkg.sv
// Package for the lattice site index generator: widths, codes and types.
// Used by every module of the block; depends on nothing.
package lsig_pkg;

  localparam int EXT_W      = 7;
  localparam int COORD_W    = 6;
  localparam int DIR_W      = 2;
  localparam int OP_W       = 4;
  localparam int VOL_W      = 25;
  localparam int IDX_W      = 26;
  localparam int MAX_EXTENT = 64;
  localparam int NUM_DIRS   = 4;
  localparam int NDIM       = NUM_DIRS;

  localparam int A_W   = EXT_W + COORD_W;
  localparam int B_W   = EXT_W + A_W;
  localparam int LEX_W = EXT_W + B_W;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam int PIPE_LAT  = 4;

  localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(MAX_EXTENT);

  typedef enum logic [OP_W-1:0] {
    OP_XYZT      = 4'd0,
    OP_CB_O      = 4'd1,
    OP_CB_E      = 4'd2,
    OP_TXYZ_HALF = 4'd3,
    OP_SURFACE   = 4'd4,
    OP_G_XYZT    = 4'd5,
    OP_G_TXYZ    = 4'd6,
    OP_G_TXYZ_CB = 4'd7,
    OP_G_CB_O    = 4'd8,
    OP_G_CB_E    = 4'd9
  } op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_EXTENT_X      = 3'd0,
    REG_EXTENT_Y      = 3'd1,
    REG_EXTENT_Z      = 3'd2,
    REG_EXTENT_T      = 3'd3,
    REG_VOLUME        = 3'd4,
    REG_PARITY_OFFSET = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
    logic [EXT_W-1:0] ext_t;
    logic [VOL_W-1:0] volume;
    logic             parity_offset;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] t;
    logic [DIR_W-1:0]   dir;
  } item_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DIR_W-1:0] dir;
    logic             par;
    logic [B_W-1:0]   surf;
    logic [LEX_W-1:0] lex;
    logic [LEX_W-1:0] txyz;
    logic [IDX_W-1:0] muv;
  } mul_t;

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    return (v > EXT_MAX) ? EXT_MAX : v;
  endfunction

endpackage

// File: design/lattice_site_index_generator.sv
// Top level of the lattice site index generator: register file, multiply
// chain and order select stage. Depends on lsig_pkg and the assertion header.
//
// Usage: the block turns one site (four coordinates, a link direction and
// an order code) into a storage index. A word is taken at each rising edge
// where start_i is high and busy_o is low; busy_o never rises, so a new word
// may be given in every cycle. The index is on index_o with valid_o high
// for exactly one cycle, after it has passed three multiply-accumulate
// stages and one select-and-add stage, each registered, in that order.
// Throughput is one word per cycle, set by the fully pipelined datapath.
// The extents, volume and parity offset are written through the APB-style
// port at byte address 4*i and are read back the same way; the user must
// make writes only while no word is in flight, which the block itself does
// not enforce. Reset clears the pipeline valid bits and loads extents of
// 8, a volume of 4096 and a parity offset of 0. The receiver cannot stall
// the block: each result must be taken in its cycle.
module lattice_site_index_generator import lsig_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [COORD_W-1:0] coord_z_i,
  input  logic [COORD_W-1:0] coord_t_i,
  input  logic [DIR_W-1:0]   direction_i,
  output logic               valid_o,
  output logic [IDX_W-1:0]   index_o
);

  `include "lattice_site_index_generator_assert.svh"

  cfg_t  cfg;
  item_t item;
  mul_t  mul;
  logic  mul_valid;
  logic  in_valid;
  logic  ext_ok;
  logic  vol_wr;
  logic [VOL_W-1:0] vol_wdata;

  assign pready   = 1'b1;
  assign busy_o   = 1'b0;
  assign in_valid = start_i & ~busy_o;

  assign item.op  = op_i;
  assign item.x   = coord_x_i;
  assign item.y   = coord_y_i;
  assign item.z   = coord_z_i;
  assign item.t   = coord_t_i;
  assign item.dir = direction_i;

  lsig_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  lsig_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid),
    .item_i  (item),
    .valid_o (mul_valid),
    .mul_o   (mul)
  );

  lsig_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (mul_valid),
    .mul_i   (mul),
    .valid_o (valid_o),
    .index_o (index_o)
  );

  assign ext_ok    = (cfg.ext_x <= EXT_MAX) && (cfg.ext_y <= EXT_MAX) &&
                     (cfg.ext_z <= EXT_MAX) && (cfg.ext_t <= EXT_MAX);
  assign vol_wr    = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_VOLUME);
  assign vol_wdata = pwdata[VOL_W-1:0];

  `LSIG_ASSERT_DLY(a_word_out, clk_i, rst_ni, in_valid, PIPE_LAT, valid_o, "accepted word lost")
  `LSIG_ASSERT_DLY(a_no_extra, clk_i, rst_ni, !in_valid, PIPE_LAT, !valid_o, "spurious result")
  `LSIG_ASSERT_IMP(a_ext_clamp, clk_i, rst_ni, 1'b1, ext_ok, "extent above its limit")
  `LSIG_ASSERT_NXT(a_vol_wr, clk_i, rst_ni, vol_wr, cfg.volume == $past(vol_wdata), "volume lost")

endmodule

// File: design/lsig_regs.sv
// Configuration register file of the lattice site index generator.
// Decodes APB-style writes and reads; depends on lsig_pkg.
module lsig_regs import lsig_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q;
  cfg_t             cfg_d;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_EXTENT_X:      cfg_d.ext_x = clamp_extent(pwdata[EXT_W-1:0]);
        REG_EXTENT_Y:      cfg_d.ext_y = clamp_extent(pwdata[EXT_W-1:0]);
        REG_EXTENT_Z:      cfg_d.ext_z = clamp_extent(pwdata[EXT_W-1:0]);
        REG_EXTENT_T:      cfg_d.ext_t = clamp_extent(pwdata[EXT_W-1:0]);
        REG_VOLUME:        cfg_d.volume = pwdata[VOL_W-1:0];
        REG_PARITY_OFFSET: cfg_d.parity_offset = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ext_x         <= EXT_W'(8);
      cfg_q.ext_y         <= EXT_W'(8);
      cfg_q.ext_z         <= EXT_W'(8);
      cfg_q.ext_t         <= EXT_W'(8);
      cfg_q.volume        <= VOL_W'(4096);
      cfg_q.parity_offset <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXTENT_X:      prdata = DATA_W'(cfg_q.ext_x);
      REG_EXTENT_Y:      prdata = DATA_W'(cfg_q.ext_y);
      REG_EXTENT_Z:      prdata = DATA_W'(cfg_q.ext_z);
      REG_EXTENT_T:      prdata = DATA_W'(cfg_q.ext_t);
      REG_VOLUME:        prdata = DATA_W'(cfg_q.volume);
      REG_PARITY_OFFSET: prdata = DATA_W'(cfg_q.parity_offset);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/lsig_mul.sv
// Three-stage multiply-accumulate chain that builds the lexical, txyz and
// surface site orders from the coordinates; depends on lsig_pkg.
module lsig_mul import lsig_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output mul_t  mul_o
);

  // Stage 1: innermost products and the link offset.
  logic             s1_valid_q;
  item_t            s1_item_q;
  logic [A_W-1:0]   s1_a_q, s1_a_d;
  logic [A_W-1:0]   s1_c_q, s1_c_d;
  logic             s1_par_q, s1_par_d;
  logic [IDX_W-1:0] s1_muv_q, s1_muv_d;

  // Stage 2: middle products.
  logic             s2_valid_q;
  item_t            s2_item_q;
  logic             s2_par_q;
  logic [IDX_W-1:0] s2_muv_q;
  logic [B_W-1:0]   s2_b_q, s2_b_d;
  logic [B_W-1:0]   s2_s_q, s2_s_d;

  // Stage 3: outer products.
  logic             s3_valid_q;
  item_t            s3_item_q;
  logic             s3_par_q;
  logic [IDX_W-1:0] s3_muv_q;
  logic [B_W-1:0]   s3_s_q;
  logic [LEX_W-1:0] s3_lex_q, s3_lex_d;
  logic [LEX_W-1:0] s3_txyz_q, s3_txyz_d;

  always_comb begin
    s1_a_d   = A_W'(cfg_i.ext_z) * A_W'(item_i.t) + A_W'(item_i.z);
    s1_c_d   = A_W'(cfg_i.ext_y) * A_W'(item_i.z) + A_W'(item_i.y);
    s1_par_d = item_i.x[0] ^ item_i.y[0] ^ item_i.z[0] ^ item_i.t[0];
    s1_muv_d = IDX_W'(item_i.dir) * IDX_W'(cfg_i.volume);
    s2_b_d   = B_W'(cfg_i.ext_y) * B_W'(s1_a_q) + B_W'(s1_item_q.y);
    s2_s_d   = B_W'(cfg_i.ext_x) * B_W'(s1_c_q) + B_W'(s1_item_q.x);
    s3_lex_d  = LEX_W'(cfg_i.ext_x) * LEX_W'(s2_b_q) + LEX_W'(s2_item_q.x);
    s3_txyz_d = LEX_W'(cfg_i.ext_t) * LEX_W'(s2_s_q) + LEX_W'(s2_item_q.t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    s1_a_q    <= s1_a_d;
    s1_c_q    <= s1_c_d;
    s1_par_q  <= s1_par_d;
    s1_muv_q  <= s1_muv_d;
    s2_item_q <= s1_item_q;
    s2_par_q  <= s1_par_q;
    s2_muv_q  <= s1_muv_q;
    s2_b_q    <= s2_b_d;
    s2_s_q    <= s2_s_d;
    s3_item_q <= s2_item_q;
    s3_par_q  <= s2_par_q;
    s3_muv_q  <= s2_muv_q;
    s3_s_q    <= s2_s_q;
    s3_lex_q  <= s3_lex_d;
    s3_txyz_q <= s3_txyz_d;
  end

  assign valid_o    = s3_valid_q;
  assign mul_o.op   = s3_item_q.op;
  assign mul_o.dir  = s3_item_q.dir;
  assign mul_o.par  = s3_par_q;
  assign mul_o.surf = s3_s_q;
  assign mul_o.lex  = s3_lex_q;
  assign mul_o.txyz = s3_txyz_q;
  assign mul_o.muv  = s3_muv_q;

endmodule

// File: design/lsig_sel.sv
// Final stage: picks the storage order, adds the link and parity offsets
// and registers the index word; depends on lsig_pkg.
module lsig_sel import lsig_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  mul_t             mul_i,
  output logic             valid_o,
  output logic [IDX_W-1:0] index_o
);

  logic             valid_q;
  logic [IDX_W-1:0] index_q, index_d;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] half_vol;
  logic [IDX_W-1:0] half_lex;
  logic             use_muv;
  logic             use_half;
  logic             odd_site;

  assign half_vol = IDX_W'(cfg_i.volume >> 1);
  assign half_lex = IDX_W'(mul_i.lex >> 1);
  assign odd_site = mul_i.par ^ cfg_i.parity_offset;

  always_comb begin
    base     = '0;
    use_muv  = 1'b0;
    use_half = 1'b0;
    case (op_e'(mul_i.op))
      OP_XYZT: begin
        base = IDX_W'(mul_i.lex);
      end
      OP_CB_O: begin
        base     = half_lex;
        use_half = !odd_site;
      end
      OP_CB_E: begin
        base     = half_lex;
        use_half = odd_site;
      end
      OP_TXYZ_HALF: begin
        base = IDX_W'(mul_i.txyz >> 1);
      end
      OP_SURFACE: begin
        base = IDX_W'(mul_i.surf >> 1);
      end
      OP_G_XYZT: begin
        base = IDX_W'({mul_i.lex, mul_i.dir});
      end
      OP_G_TXYZ: begin
        base    = IDX_W'(mul_i.txyz);
        use_muv = 1'b1;
      end
      OP_G_TXYZ_CB: begin
        base     = IDX_W'(mul_i.txyz >> 1);
        use_muv  = 1'b1;
        use_half = mul_i.par;
      end
      OP_G_CB_O: begin
        base     = half_lex;
        use_muv  = 1'b1;
        use_half = !odd_site;
      end
      OP_G_CB_E: begin
        base     = half_lex;
        use_muv  = 1'b1;
        use_half = odd_site;
      end
      default: begin
        base = '0;
      end
    endcase
    index_d = base + (use_muv ? mul_i.muv : '0) + (use_half ? half_vol : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
  end

  assign valid_o = valid_q;
  assign index_o = index_q;

endmodule
